// ===== rtl/cbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared constants and types for the cubic Bezier split unit.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int T_FRAC_BITS_DEF = 16;

  // register stages through one interpolation unit
  localparam int LERP_LAT = 3;

  typedef struct packed {
    logic valid;
    logic has_s;
    logic has_e;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/cubic_bezier_split_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_split_unit
// De Casteljau split of one path segment at parameter t.
//
//   channel   handshake        payload
//   -------   --------------   ------------------------------------------
//   input     start / busy     start/end nodes, tangents, has flags, split_t
//   result    done (strobe)    mid node, mid tangents, new end tangents
//
// One transaction per cycle is accepted except during reset; each result passes
// through the input register, three interpolation levels of three stages each,
// and the output register.
// Reset clears the valid/control pipeline; busy is high only during reset.
// The receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module cubic_bezier_split_unit #(
  parameter int COORD_BITS  = cbs_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic                         start_has_tangent,
  input  logic signed [COORD_BITS-1:0] start_tan_x,
  input  logic signed [COORD_BITS-1:0] start_tan_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         end_has_tangent,
  input  logic signed [COORD_BITS-1:0] end_tan_x,
  input  logic signed [COORD_BITS-1:0] end_tan_y,
  input  logic        [T_FRAC_BITS:0]  split_t,
  output logic                         done,
  output logic signed [COORD_BITS:0]   mid_x,
  output logic signed [COORD_BITS:0]   mid_y,
  output logic                         mid_smooth,
  output logic signed [COORD_BITS+1:0] mid_in_x,
  output logic signed [COORD_BITS+1:0] mid_in_y,
  output logic signed [COORD_BITS+1:0] mid_out_x,
  output logic signed [COORD_BITS+1:0] mid_out_y,
  output logic signed [COORD_BITS:0]   new_start_tan_x,
  output logic signed [COORD_BITS:0]   new_start_tan_y,
  output logic signed [COORD_BITS:0]   new_end_tan_x,
  output logic signed [COORD_BITS:0]   new_end_tan_y
);

  import cbs_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int TB     = T_FRAC_BITS;
  localparam int PW     = C + 1;
  localparam int CDEPTH = 3 * LERP_LAT + 1;
  localparam int LAT    = 3 * LERP_LAT + 2;
  localparam logic [TB:0] T_ONE = {1'b1, {TB{1'b0}}};

  // stage 0: control points
  logic signed [PW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
  logic        [TB:0]   t0;
  ctl_t                 ctl [CDEPTH];

  assign busy = rst;

  always_ff @(posedge clk) begin
    p0x <= {start_x[C-1], start_x};
    p0y <= {start_y[C-1], start_y};
    p3x <= {end_x[C-1], end_x};
    p3y <= {end_y[C-1], end_y};
    p1x <= start_has_tangent ? {start_x[C-1], start_x} + {start_tan_x[C-1], start_tan_x}
                             : {start_x[C-1], start_x};
    p1y <= start_has_tangent ? {start_y[C-1], start_y} + {start_tan_y[C-1], start_tan_y}
                             : {start_y[C-1], start_y};
    p2x <= end_has_tangent ? {end_x[C-1], end_x} + {end_tan_x[C-1], end_tan_x}
                           : {end_x[C-1], end_x};
    p2y <= end_has_tangent ? {end_y[C-1], end_y} + {end_tan_y[C-1], end_tan_y}
                           : {end_y[C-1], end_y};
    t0  <= (split_t > T_ONE) ? T_ONE : split_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CDEPTH; i++) begin
        ctl[i] <= '0;
      end
    end else begin
      ctl[0].valid <= start && !busy;
      ctl[0].has_s <= start_has_tangent;
      ctl[0].has_e <= end_has_tangent;
      for (int i = 1; i < CDEPTH; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  // level 1: p01, p12, p23 and the straight-line point
  logic signed [PW-1:0] l1_a [8];
  logic signed [PW-1:0] l1_b [8];
  logic signed [PW-1:0] l1_y [8];
  logic        [TB:0]   t1, t2;

  always_comb begin
    l1_a[0] = p0x; l1_b[0] = p1x;
    l1_a[1] = p0y; l1_b[1] = p1y;
    l1_a[2] = p1x; l1_b[2] = p2x;
    l1_a[3] = p1y; l1_b[3] = p2y;
    l1_a[4] = p2x; l1_b[4] = p3x;
    l1_a[5] = p2y; l1_b[5] = p3y;
    l1_a[6] = p0x; l1_b[6] = p3x;
    l1_a[7] = p0y; l1_b[7] = p3y;
  end

  for (genvar g = 0; g < 8; g++) begin : g_l1
    cbs_lerp #(.W(PW), .TB(TB)) u_lerp (
      .clk (clk),
      .a   (l1_a[g]),
      .b   (l1_b[g]),
      .t   (t0),
      .y   (l1_y[g])
    );
  end

  cbs_delay #(.W(TB + 1), .DEPTH(LERP_LAT)) u_dly_t1 (.clk(clk), .d(t0), .q(t1));
  cbs_delay #(.W(TB + 1), .DEPTH(LERP_LAT)) u_dly_t2 (.clk(clk), .d(t1), .q(t2));

  // level 2: p012, p123
  logic signed [PW-1:0] l2_y [4];

  cbs_lerp #(.W(PW), .TB(TB)) u_l2_0 (.clk(clk), .a(l1_y[0]), .b(l1_y[2]), .t(t1), .y(l2_y[0]));
  cbs_lerp #(.W(PW), .TB(TB)) u_l2_1 (.clk(clk), .a(l1_y[1]), .b(l1_y[3]), .t(t1), .y(l2_y[1]));
  cbs_lerp #(.W(PW), .TB(TB)) u_l2_2 (.clk(clk), .a(l1_y[2]), .b(l1_y[4]), .t(t1), .y(l2_y[2]));
  cbs_lerp #(.W(PW), .TB(TB)) u_l2_3 (.clk(clk), .a(l1_y[3]), .b(l1_y[5]), .t(t1), .y(l2_y[3]));

  // level 3: middle point
  logic signed [PW-1:0] l3x, l3y;

  cbs_lerp #(.W(PW), .TB(TB)) u_l3_x (.clk(clk), .a(l2_y[0]), .b(l2_y[2]), .t(t2), .y(l3x));
  cbs_lerp #(.W(PW), .TB(TB)) u_l3_y (.clk(clk), .a(l2_y[1]), .b(l2_y[3]), .t(t2), .y(l3y));

  // side data aligned with level 3 output
  logic [4*PW-1:0] ends_q;
  logic [6*PW-1:0] l1_q;
  logic [4*PW-1:0] l2_q;

  cbs_delay #(.W(4 * PW), .DEPTH(3 * LERP_LAT)) u_dly_ends (
    .clk (clk),
    .d   ({p0x, p0y, p3x, p3y}),
    .q   (ends_q)
  );

  cbs_delay #(.W(6 * PW), .DEPTH(2 * LERP_LAT)) u_dly_l1 (
    .clk (clk),
    .d   ({l1_y[0], l1_y[1], l1_y[4], l1_y[5], l1_y[6], l1_y[7]}),
    .q   (l1_q)
  );

  cbs_delay #(.W(4 * PW), .DEPTH(LERP_LAT)) u_dly_l2 (
    .clk (clk),
    .d   ({l2_y[0], l2_y[1], l2_y[2], l2_y[3]}),
    .q   (l2_q)
  );

  logic signed [PW-1:0] e0x, e0y, e3x, e3y;
  logic signed [PW-1:0] q01x, q01y, q23x, q23y, qcx, qcy;
  logic signed [PW-1:0] q012x, q012y, q123x, q123y;

  assign {e0x, e0y, e3x, e3y}                 = ends_q;
  assign {q01x, q01y, q23x, q23y, qcx, qcy}   = l1_q;
  assign {q012x, q012y, q123x, q123y}         = l2_q;

  // output register
  ctl_t                 cl;
  logic                 smooth;
  logic signed [PW-1:0] mx, my;

  assign cl     = ctl[CDEPTH-1];
  assign smooth = cl.has_s || cl.has_e;
  assign mx     = smooth ? l3x : qcx;
  assign my     = smooth ? l3y : qcy;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cl.valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_x      <= mx;
    mid_y      <= my;
    mid_smooth <= smooth;
    mid_in_x   <= smooth ? {q012x[PW-1], q012x} - {mx[PW-1], mx} : '0;
    mid_in_y   <= smooth ? {q012y[PW-1], q012y} - {my[PW-1], my} : '0;
    mid_out_x  <= smooth ? {q123x[PW-1], q123x} - {mx[PW-1], mx} : '0;
    mid_out_y  <= smooth ? {q123y[PW-1], q123y} - {my[PW-1], my} : '0;
    new_start_tan_x <= cl.has_s ? q01x - e0x : '0;
    new_start_tan_y <= cl.has_s ? q01y - e0y : '0;
    new_end_tan_x   <= cl.has_e ? q23x - e3x : '0;
    new_end_tan_y   <= cl.has_e ? q23y - e3y : '0;
  end

  a_done_follows_start : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching input transaction");

  a_smooth_flag : assert property (@(posedge clk) disable iff (rst)
    done |-> mid_smooth == $past(start_has_tangent || end_has_tangent, LAT))
    else $error("smooth flag does not match the tangent flags");

  a_corner_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !mid_smooth) |-> (mid_in_x == '0 && mid_out_y == '0 &&
                               new_start_tan_x == '0 && new_end_tan_y == '0))
    else $error("corner result carries a nonzero tangent");

  a_t_zero : assert property (@(posedge clk) disable iff (rst)
    (done && $past(split_t == '0, LAT)) |->
      mid_x == $signed({$past(start_x[C-1], LAT), $past(start_x, LAT)}))
    else $error("split at zero does not return the start point");

endmodule
`default_nettype wire

// ===== rtl/cbs_lerp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_lerp
// Three-stage interpolation a + (b - a) * t, t in fixed point with TB
// fraction bits, rounded half away from zero to an integer.
// ----------------------------------------------------------------------------
module cbs_lerp #(
  parameter int W  = 25,
  parameter int TB = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic        [TB:0]  t,
  output logic signed [W-1:0] y
);

  localparam int NW = W + TB + 2;
  localparam logic [NW-1:0] HALF    = NW'(1) << (TB - 1);
  localparam logic [NW-1:0] HALF_M1 = HALF - NW'(1);

  logic signed [W-1:0]    a_q;
  logic signed [W:0]      d_q;
  logic        [TB:0]     t_q;
  logic signed [W+TB+2:0] prod;
  logic signed [NW-1:0]   base;
  logic signed [NW-1:0]   num_next;
  logic signed [NW-1:0]   num_q;
  logic        [NW-1:0]   rnd;
  logic signed [W-1:0]    y_q;

  always_ff @(posedge clk) begin
    a_q <= a;
    d_q <= {b[W-1], b} - {a[W-1], a};
    t_q <= t;
  end

  assign prod     = d_q * $signed({1'b0, t_q});
  assign base     = {{2{a_q[W-1]}}, a_q, {TB{1'b0}}};
  assign num_next = base + prod[NW-1:0];

  always_ff @(posedge clk) begin
    num_q <= num_next;
  end

  assign rnd = num_q + (num_q[NW-1] ? HALF_M1 : HALF);

  always_ff @(posedge clk) begin
    y_q <= rnd[TB+W-1:TB];
  end

  assign y = y_q;

endmodule
`default_nettype wire

// ===== rtl/cbs_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_delay
// Fixed-length register line that keeps side data aligned with the
// interpolation stages.
// ----------------------------------------------------------------------------
module cbs_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 3
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule
`default_nettype wire
